FILE: rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed: lbl");

// next-cycle implication
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: lbl");

`endif

FILE: rtl/core/scps_pkg.sv
// shared types, keyword tables and opcodes of the serial command power supervisor
`default_nettype none
package scps_pkg;

   localparam int KW_BITS = 224;
   localparam int KW_COUNT = 21;

   localparam int KW_HOST = 0;
   localparam int KW_POWER = 1;
   localparam int KW_LCD = 2;
   localparam int KW_WD = 3;
   localparam int KW_SELF = 4;
   localparam int KW_ON = 5;
   localparam int KW_OFF = 6;
   localparam int KW_DEV_ON = 7;
   localparam int KW_DEV_OFF = 13;
   localparam int DEV_MIC = 0;
   localparam int DEV_MODEM = 1;
   localparam int DEV_WIFI = 2;
   localparam int DEV_HUB = 3;
   localparam int DEV_HD = 4;
   localparam int DEV_LCD = 5;
   localparam int KW_ENABLE = 19;
   localparam int KW_DISABLE = 20;

   // board and controller names and the modem device, as raw bytes
   localparam logic [87:0] TAG_HOST = 88'h426561676c65626f617264;
   localparam logic [23:0] TAG_MCU = 24'h415652;
   localparam logic [39:0] TAG_MODEM = 40'h6e65787467;

   localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
      KW_BITS'({"REALLY reset the ", TAG_HOST}), KW_BITS'("power"), KW_BITS'("lcd"),
      KW_BITS'("watchdog"), KW_BITS'({"REALLY reset the ", TAG_MCU}), KW_BITS'("on"),
      KW_BITS'("off"),
      KW_BITS'("usbmic"), KW_BITS'(TAG_MODEM), KW_BITS'("wifi"), KW_BITS'("usbhub"),
      KW_BITS'("usbhd"), KW_BITS'("lcd"),
      KW_BITS'("usbmic"), KW_BITS'(TAG_MODEM), KW_BITS'("wifi"), KW_BITS'("usbhub"),
      KW_BITS'("usbhd"), KW_BITS'("lcd"),
      KW_BITS'("enable"), KW_BITS'("disable")};
   localparam int KW_LEN [KW_COUNT] = '{28, 5, 3, 8, 20, 2, 3,
      6, 5, 4, 6, 5, 3, 6, 5, 4, 6, 5, 3, 6, 7};
   localparam int KW_POS [KW_COUNT] = '{0, 0, 0, 0, 0, 6, 6,
      9, 9, 9, 9, 9, 9, 10, 10, 10, 10, 10, 10, 9, 9};

   localparam logic [63:0] MARKER = {"#=# ", TAG_MCU, " "};
   localparam logic [7:0] CHAR_LF = 8'h0a;
   localparam logic [7:0] CHAR_CR = 8'h0d;
   localparam logic [7:0] CHAR_ONE = 8'h31;
   localparam logic [7:0] CHAR_EIGHT = 8'h38;

   localparam logic [3:0] ST_NONE = 4'd0;
   localparam logic [3:0] ST_POWER_DONE = 4'd1;
   localparam logic [3:0] ST_UNKNOWN_CMD = 4'd2;
   localparam logic [3:0] ST_BAD_ONOFF = 4'd3;
   localparam logic [3:0] ST_UNKNOWN_DEV = 4'd4;
   localparam logic [3:0] ST_HOST_RESET = 4'd5;
   localparam logic [3:0] ST_WD_ENABLE = 4'd6;
   localparam logic [3:0] ST_WD_DISABLE = 4'd7;
   localparam logic [3:0] ST_LCD_CMD = 4'd8;
   localparam logic [3:0] ST_BAD_WD_ARG = 4'd9;

   localparam logic [1:0] CSR_WD_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_RESTART_SECONDS = 2'd1;
   localparam logic [1:0] CSR_DRY_RUN = 2'd2;
   localparam logic [1:0] CSR_PIN_MIRROR = 2'd3;

   typedef enum logic [3:0] {
      OP_TICK, OP_BYTE, OP_HOST, OP_POWER, OP_POWER_LCD, OP_STATUS,
      OP_WD_EN, OP_WD_DIS, OP_SELF
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [3:0] status;
      logic       turn_on;
      logic       is_digit;
      logic [2:0] pin;
   } entry_type;

   function automatic logic kw_ok(input int k, input logic [5:0] p, input logic [7:0] b);
      int idx;
      logic ok;
      idx = int'(p) - KW_POS[k];
      ok = 1'b1;
      if (idx >= 0 && idx < KW_LEN[k]) begin
         ok = (KW_TEXT[k][8*(KW_LEN[k]-1-idx) +: 8] == b);
      end
      return ok;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/scps_queue.sv
// small fifo between the command front end and the execution back end
`default_nettype none
module scps_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_en,
   input  wire scps_pkg::entry_type wr_data,
   output logic                    q_full,
   input  wire logic               rd_en,
   output scps_pkg::entry_type     rd_data,
   output logic                    q_empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   scps_pkg::entry_type mem_ff [DEPTH];
   logic [PW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic do_wr, do_rd;

   assign q_full = (count_ff == CW'(DEPTH));
   assign q_empty = (count_ff == '0);
   assign do_wr = wr_en && !q_full;
   assign do_rd = rd_en && !q_empty;
   assign rd_data = mem_ff[head_ff];

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      count_in = count_ff;
      if (do_wr) begin
         tail_in = (tail_ff == PW'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (do_rd) begin
         head_in = (head_ff == PW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[tail_ff] <= wr_data;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/core/scps_front.sv
// front end: marker framing, line collection, keyword matching and command decode
`default_nettype none
module scps_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic               item_type,
   input  wire logic [7:0]         item_byte,
   output scps_pkg::entry_type     entry
);
   logic [2:0] prefix_pos_ff, prefix_pos_in;
   logic in_line_ff, in_line_in;
   logic [5:0] line_len_ff, line_len_in;
   logic [scps_pkg::KW_COUNT-1:0] flags_ff, flags_in, hit;
   logic [7:0] d9_ff, d9_in, d10_ff, d10_in;
   logic line_end, dig_ok;
   logic [7:0] dig;
   int base;

   assign line_end = in_line_ff &&
      (item_byte == scps_pkg::CHAR_LF || item_byte == scps_pkg::CHAR_CR);

   always_comb begin
      for (int k = 0; k < scps_pkg::KW_COUNT; k++) begin
         hit[k] = flags_ff[k] &&
            (int'(line_len_ff) >= scps_pkg::KW_POS[k] + scps_pkg::KW_LEN[k]);
      end
   end

   always_comb begin
      prefix_pos_in = prefix_pos_ff;
      in_line_in = in_line_ff;
      line_len_in = line_len_ff;
      flags_in = flags_ff;
      d9_in = d9_ff;
      d10_in = d10_ff;
      if (!item_type) begin
         if (in_line_ff) begin
            if (line_end) begin
               in_line_in = 1'b0;
               line_len_in = '0;
            end else if (line_len_ff != 6'h3f) begin
               line_len_in = line_len_ff + 1'b1;
               for (int k = 0; k < scps_pkg::KW_COUNT; k++) begin
                  flags_in[k] = flags_ff[k] & scps_pkg::kw_ok(k, line_len_ff, item_byte);
               end
               if (line_len_ff == 6'd9) begin
                  d9_in = item_byte;
               end
               if (line_len_ff == 6'd10) begin
                  d10_in = item_byte;
               end
            end
         end else if (item_byte == scps_pkg::MARKER[8*(7-int'(prefix_pos_ff)) +: 8]) begin
            if (prefix_pos_ff == 3'd7) begin
               prefix_pos_in = '0;
               in_line_in = 1'b1;
               line_len_in = '0;
               flags_in = '1;
            end else begin
               prefix_pos_in = prefix_pos_ff + 1'b1;
            end
         end else begin
            prefix_pos_in = '0;
         end
      end
   end

   always_comb begin
      entry.op = scps_pkg::OP_BYTE;
      entry.status = scps_pkg::ST_NONE;
      entry.turn_on = 1'b0;
      entry.is_digit = 1'b0;
      entry.pin = '0;
      base = hit[scps_pkg::KW_ON] ? scps_pkg::KW_DEV_ON : scps_pkg::KW_DEV_OFF;
      dig = hit[scps_pkg::KW_ON] ? d9_ff : d10_ff;
      dig_ok = (hit[scps_pkg::KW_ON] ? (line_len_ff > 6'd9) : (line_len_ff > 6'd10)) &&
         dig >= scps_pkg::CHAR_ONE && dig <= scps_pkg::CHAR_EIGHT;
      if (item_type) begin
         entry.op = scps_pkg::OP_TICK;
      end else if (line_end) begin
         if (hit[scps_pkg::KW_HOST]) begin
            entry.op = scps_pkg::OP_HOST;
         end else if (hit[scps_pkg::KW_POWER]) begin
            entry.turn_on = hit[scps_pkg::KW_ON];
            entry.op = scps_pkg::OP_POWER;
            if (!hit[scps_pkg::KW_ON] && !hit[scps_pkg::KW_OFF]) begin
               entry.op = scps_pkg::OP_STATUS;
               entry.status = scps_pkg::ST_BAD_ONOFF;
            end else if (dig_ok) begin
               entry.is_digit = 1'b1;
               entry.pin = 3'(dig - scps_pkg::CHAR_ONE);
            end else if (hit[base + scps_pkg::DEV_MIC]) begin
               entry.pin = 3'd1;
            end else if (hit[base + scps_pkg::DEV_MODEM]) begin
               entry.pin = 3'd4;
            end else if (hit[base + scps_pkg::DEV_WIFI]) begin
               entry.pin = 3'd5;
            end else if (hit[base + scps_pkg::DEV_HUB]) begin
               entry.pin = 3'd2;
            end else if (hit[base + scps_pkg::DEV_HD]) begin
               entry.pin = 3'd3;
            end else if (hit[base + scps_pkg::DEV_LCD]) begin
               entry.op = scps_pkg::OP_POWER_LCD;
            end else begin
               entry.op = scps_pkg::OP_STATUS;
               entry.status = scps_pkg::ST_UNKNOWN_DEV;
            end
         end else if (hit[scps_pkg::KW_LCD]) begin
            entry.op = scps_pkg::OP_STATUS;
            entry.status = scps_pkg::ST_LCD_CMD;
         end else if (hit[scps_pkg::KW_WD]) begin
            if (hit[scps_pkg::KW_ENABLE]) begin
               entry.op = scps_pkg::OP_WD_EN;
            end else if (hit[scps_pkg::KW_DISABLE]) begin
               entry.op = scps_pkg::OP_WD_DIS;
            end else begin
               entry.op = scps_pkg::OP_STATUS;
               entry.status = scps_pkg::ST_BAD_WD_ARG;
            end
         end else if (hit[scps_pkg::KW_SELF]) begin
            entry.op = scps_pkg::OP_SELF;
         end else begin
            entry.op = scps_pkg::OP_STATUS;
            entry.status = scps_pkg::ST_UNKNOWN_CMD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_pos_ff <= '0;
         in_line_ff <= 1'b0;
         line_len_ff <= '0;
         flags_ff <= '0;
      end else if (accept) begin
         prefix_pos_ff <= prefix_pos_in;
         in_line_ff <= in_line_in;
         line_len_ff <= line_len_in;
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         d9_ff <= d9_in;
         d10_ff <= d10_in;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/core/scps_back.sv
// back end: power port, watchdog, restart countdown and result register
`default_nettype none
module scps_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire scps_pkg::entry_type entry,
   input  wire logic               q_empty,
   output logic                    q_pop,
   input  wire logic [15:0]        watchdog_timeout,
   input  wire logic [7:0]         restart_seconds,
   input  wire logic               dry_run,
   input  wire logic               pin_mirror,
   output logic                    empty,
   input  wire logic               pop,
   output logic [7:0]              supply_n,
   output logic                    lcd_power,
   output logic                    watchdog_on,
   output logic [3:0]              cmd_status,
   output logic [2:0]              report_pin,
   output logic                    report_state,
   output logic                    watchdog_fired,
   output logic                    host_restored,
   output logic                    self_reset_request
);
   logic [7:0] port_ff, port_in;
   logic lcd_ff, lcd_in, wd_en_ff, wd_en_in;
   logic [15:0] wd_count_ff, wd_count_in;
   logic [7:0] rc_ff, rc_in;
   logic ra_ff, ra_in;
   logic valid_ff;
   logic [3:0] st_ff, st_in;
   logic [2:0] rpin_ff, rpin_in;
   logic ron_ff, ron_in, fired_ff, fired_in, rest_ff, rest_in, self_ff, self_in;
   logic [2:0] host_pin, p;
   logic [16:0] c;

   assign q_pop = !q_empty && (!valid_ff || pop);
   assign host_pin = pin_mirror ? 3'd0 : 3'd7;
   assign empty = !valid_ff;
   assign supply_n = port_ff;
   assign lcd_power = lcd_ff;
   assign watchdog_on = wd_en_ff;
   assign cmd_status = st_ff;
   assign report_pin = rpin_ff;
   assign report_state = ron_ff;
   assign watchdog_fired = fired_ff;
   assign host_restored = rest_ff;
   assign self_reset_request = self_ff;

   always_comb begin
      port_in = port_ff;
      lcd_in = lcd_ff;
      wd_en_in = wd_en_ff;
      wd_count_in = wd_count_ff;
      rc_in = rc_ff;
      ra_in = ra_ff;
      st_in = scps_pkg::ST_NONE;
      rpin_in = '0;
      ron_in = 1'b0;
      fired_in = 1'b0;
      rest_in = 1'b0;
      self_in = 1'b0;
      c = {1'b0, wd_count_ff} + 17'd1;
      p = entry.pin;
      if (entry.is_digit && pin_mirror) begin
         p = 3'd7 - entry.pin;
      end
      if (entry.op == scps_pkg::OP_TICK) begin
         if (ra_ff) begin
            if (rc_ff <= 8'd1) begin
               rc_in = '0;
               ra_in = 1'b0;
               port_in[host_pin] = 1'b0;
               rest_in = 1'b1;
            end else begin
               rc_in = rc_ff - 1'b1;
            end
         end
         if (wd_en_ff) begin
            if (c > {1'b0, watchdog_timeout}) begin
               fired_in = 1'b1;
               wd_count_in = '0;
               if (!dry_run) begin
                  port_in[host_pin] = 1'b1;
                  rc_in = restart_seconds;
                  ra_in = 1'b1;
               end
            end else begin
               wd_count_in = c[15:0];
            end
         end
      end else begin
         wd_count_in = '0;
         case (entry.op)
            scps_pkg::OP_HOST: begin
               port_in[host_pin] = 1'b1;
               rc_in = restart_seconds;
               ra_in = 1'b1;
               st_in = scps_pkg::ST_HOST_RESET;
            end
            scps_pkg::OP_POWER: begin
               port_in[p] = !entry.turn_on;
               st_in = scps_pkg::ST_POWER_DONE;
               rpin_in = p;
               ron_in = entry.turn_on;
            end
            scps_pkg::OP_POWER_LCD: begin
               lcd_in = entry.turn_on;
               st_in = scps_pkg::ST_POWER_DONE;
               ron_in = entry.turn_on;
            end
            scps_pkg::OP_STATUS: st_in = entry.status;
            scps_pkg::OP_WD_EN: begin
               wd_en_in = 1'b1;
               st_in = scps_pkg::ST_WD_ENABLE;
            end
            scps_pkg::OP_WD_DIS: begin
               wd_en_in = 1'b0;
               st_in = scps_pkg::ST_WD_DISABLE;
            end
            scps_pkg::OP_SELF: self_in = 1'b1;
            default: st_in = scps_pkg::ST_NONE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         port_ff <= 8'hfa;
         lcd_ff <= 1'b1;
         wd_en_ff <= 1'b1;
         wd_count_ff <= '0;
         rc_ff <= '0;
         ra_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            port_ff <= port_in;
            lcd_ff <= lcd_in;
            wd_en_ff <= wd_en_in;
            wd_count_ff <= wd_count_in;
            rc_ff <= rc_in;
            ra_ff <= ra_in;
            valid_ff <= 1'b1;
         end else if (pop) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         st_ff <= st_in;
         rpin_ff <= rpin_in;
         ron_ff <= ron_in;
         fired_ff <= fired_in;
         rest_ff <= rest_in;
         self_ff <= self_in;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/core/serial_command_power_supervisor.sv
// Serial command power supervisor. Each transaction is a serial byte or a one-second
// tick and yields exactly one result. Keywords are matched as the line arrives, so a
// line end needs no separate matching pass: a transaction passes the front end in its
// accept cycle, waits in a QUEUE_DEPTH-entry queue, and the back end retires one
// per cycle into the result register, where each result stays until it is popped;
// the sustained rate is one transaction per cycle while results are popped.
// Configuration writes are always ready and take effect at once; write them only
// while no transaction is in flight.
`default_nettype none
module serial_command_power_supervisor #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic        req_type,
   input  wire logic [7:0]  req_rx_byte,
   output logic             empty,
   input  wire logic        pop,
   output logic [7:0]       rsp_supply_n,
   output logic             rsp_lcd_power,
   output logic             rsp_watchdog_on,
   output logic [3:0]       rsp_cmd_status,
   output logic [2:0]       rsp_report_pin,
   output logic             rsp_report_state,
   output logic             rsp_watchdog_fired,
   output logic             rsp_host_restored,
   output logic             rsp_self_reset_request,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   logic [15:0] wd_timeout_ff;
   logic [7:0] restart_sec_ff;
   logic dry_run_ff, pin_mirror_ff;
   logic accept, q_empty, q_pop;
   scps_pkg::entry_type f_entry, q_entry;

   assign accept = push && !full;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wd_timeout_ff <= 16'd600;
         restart_sec_ff <= 8'd10;
         dry_run_ff <= 1'b1;
         pin_mirror_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            scps_pkg::CSR_WD_TIMEOUT: wd_timeout_ff <= csr_data;
            scps_pkg::CSR_RESTART_SECONDS: restart_sec_ff <= csr_data[7:0];
            scps_pkg::CSR_DRY_RUN: dry_run_ff <= csr_data[0];
            scps_pkg::CSR_PIN_MIRROR: pin_mirror_ff <= csr_data[0];
            default: dry_run_ff <= dry_run_ff;
         endcase
      end
   end

   scps_front u_front (
      .clock(clock), .reset(reset), .accept(accept), .item_type(req_type),
      .item_byte(req_rx_byte), .entry(f_entry)
   );

   scps_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset), .wr_en(accept), .wr_data(f_entry), .q_full(full),
      .rd_en(q_pop), .rd_data(q_entry), .q_empty(q_empty)
   );

   scps_back u_back (
      .clock(clock), .reset(reset), .entry(q_entry), .q_empty(q_empty), .q_pop(q_pop),
      .watchdog_timeout(wd_timeout_ff), .restart_seconds(restart_sec_ff),
      .dry_run(dry_run_ff), .pin_mirror(pin_mirror_ff), .empty(empty), .pop(pop),
      .supply_n(rsp_supply_n), .lcd_power(rsp_lcd_power),
      .watchdog_on(rsp_watchdog_on), .cmd_status(rsp_cmd_status),
      .report_pin(rsp_report_pin), .report_state(rsp_report_state),
      .watchdog_fired(rsp_watchdog_fired), .host_restored(rsp_host_restored),
      .self_reset_request(rsp_self_reset_request)
   );
endmodule
`default_nettype wire

FILE: rtl/core/scps_checker.sv
// port-level checks of the serial command power supervisor, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module scps_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       empty,
   input wire logic       pop,
   input wire logic [7:0] rsp_supply_n,
   input wire logic [3:0] rsp_cmd_status,
   input wire logic       rsp_watchdog_fired,
   input wire logic       rsp_host_restored,
   input wire logic       rsp_self_reset_request
);
   `CHK_IMP(a_empty_after_reset, clock, reset, $past(reset), empty)
   `CHK_IMP(a_tick_no_status, clock, reset,
      !empty && (rsp_watchdog_fired || rsp_host_restored),
      rsp_cmd_status == scps_pkg::ST_NONE)
   `CHK_IMP(a_self_no_status, clock, reset, !empty && rsp_self_reset_request,
      rsp_cmd_status == scps_pkg::ST_NONE && !rsp_watchdog_fired)
   `CHK_NEXT(a_hold_port, clock, reset, !empty && !pop, $stable(rsp_supply_n))
endmodule

bind serial_command_power_supervisor scps_checker u_scps_checker (
   .clock(clock), .reset(reset), .empty(empty), .pop(pop),
   .rsp_supply_n(rsp_supply_n), .rsp_cmd_status(rsp_cmd_status),
   .rsp_watchdog_fired(rsp_watchdog_fired), .rsp_host_restored(rsp_host_restored),
   .rsp_self_reset_request(rsp_self_reset_request)
);
`default_nettype wire

FILE: bench/tb_top.sv
// self-checking testbench for the serial command power supervisor
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_KEEP = 48;
   localparam int STORE_MAX = 1024;
   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   typedef struct packed {
      logic [7:0] supply_n;
      logic       lcd_power;
      logic       watchdog_on;
      logic [3:0] cmd_status;
      logic [2:0] report_pin;
      logic       report_state;
      logic       watchdog_fired;
      logic       host_restored;
      logic       self_reset_request;
   } status_word;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic req_type = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic empty;
   logic pop = 1'b0;
   logic [7:0] rsp_supply_n;
   logic rsp_lcd_power, rsp_watchdog_on;
   logic [3:0] rsp_cmd_status;
   logic [2:0] rsp_report_pin;
   logic rsp_report_state, rsp_watchdog_fired, rsp_host_restored, rsp_self_reset_request;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = scps_pkg::CSR_WD_TIMEOUT;
   logic [15:0] csr_data = 16'h0000;

   serial_command_power_supervisor dut (.*);

   // predictor state
   logic [15:0] cfg_timeout;
   logic [7:0] cfg_restart;
   logic cfg_dry, cfg_mirror;
   int marker_pos, line_len;
   logic in_line;
   logic [7:0] line_buf [STORE_KEEP];
   logic [7:0] port_bits;
   logic lcd_flag, wd_en;
   logic [15:0] wd_count;
   logic [7:0] restart_count;
   logic restart_active;

   // command texts built from raw bytes
   string host_cmd, self_cmd, marker_txt, modem_txt;

   status_word expected_q[$];
   int errors = 0;
   int results_seen = 0;
   int lines_sent = 0;
   logic quiet = 1'b0;

   initial forever #5 clock = ~clock;

   initial begin
      #50ms;
      $display("timeout at %0t", $realtime);
      $display("Mismatches found");
      $finish;
   end

   function automatic bit line_has(int off, string s);
      if (off + s.len() > line_len) return 0;
      for (int i = 0; i < s.len(); i++) begin
         if (off + i >= STORE_KEEP || line_buf[off + i] != s[i]) return 0;
      end
      return 1;
   endfunction

   function automatic void drive_pin(int pin, bit on);
      if (on) port_bits[pin & 7] = 1'b0;
      else port_bits[pin & 7] = 1'b1;
   endfunction

   function automatic void start_host_reset();
      drive_pin(cfg_mirror ? 0 : 7, 1'b0);
      restart_count = cfg_restart;
      restart_active = 1'b1;
   endfunction

   function automatic void decode_power(ref status_word r);
      int a, d, p;
      bit on;
      a = 6;
      if (line_has(a, "on")) begin
         on = 1; d = a + 3;
      end else if (line_has(a, "off")) begin
         on = 0; d = a + 4;
      end else begin
         r.cmd_status = scps_pkg::ST_BAD_ONOFF;
         return;
      end
      if (d < line_len && d < STORE_KEEP && line_buf[d] >= scps_pkg::CHAR_ONE
            && line_buf[d] <= scps_pkg::CHAR_EIGHT) begin
         p = line_buf[d] - scps_pkg::CHAR_ONE;
         if (cfg_mirror) p = 7 - p;
      end else if (line_has(d, "usbmic")) p = 1;
      else if (line_has(d, modem_txt)) p = 4;
      else if (line_has(d, "wifi")) p = 5;
      else if (line_has(d, "usbhub")) p = 2;
      else if (line_has(d, "usbhd")) p = 3;
      else if (line_has(d, "lcd")) begin
         lcd_flag = on;
         r.cmd_status = scps_pkg::ST_POWER_DONE;
         r.report_pin = 3'd0;
         r.report_state = on;
         return;
      end else begin
         r.cmd_status = scps_pkg::ST_UNKNOWN_DEV;
         return;
      end
      drive_pin(p, on);
      r.cmd_status = scps_pkg::ST_POWER_DONE;
      r.report_pin = p[2:0];
      r.report_state = on;
   endfunction

   function automatic status_word supervisor_step(logic kind, logic [7:0] b);
      status_word r;
      logic [16:0] c;
      r = '0;
      if (kind == REQ_TICK) begin
         if (restart_active) begin
            if (restart_count <= 8'd1) begin
               restart_count = 8'd0;
               restart_active = 1'b0;
               drive_pin(cfg_mirror ? 0 : 7, 1'b1);
               r.host_restored = 1'b1;
            end else restart_count--;
         end
         if (wd_en) begin
            c = {1'b0, wd_count} + 17'd1;
            if (c > {1'b0, cfg_timeout}) begin
               r.watchdog_fired = 1'b1;
               wd_count = 16'd0;
               if (!cfg_dry) start_host_reset();
            end else wd_count = c[15:0];
         end
      end else begin
         wd_count = 16'd0;
         if (in_line) begin
            if (b == scps_pkg::CHAR_LF || b == scps_pkg::CHAR_CR) begin
               if (line_has(0, host_cmd)) begin
                  start_host_reset();
                  r.cmd_status = scps_pkg::ST_HOST_RESET;
               end else if (line_has(0, "power")) decode_power(r);
               else if (line_has(0, "lcd")) r.cmd_status = scps_pkg::ST_LCD_CMD;
               else if (line_has(0, "watchdog")) begin
                  if (line_has(9, "enable")) begin
                     wd_en = 1'b1; wd_count = 16'd0;
                     r.cmd_status = scps_pkg::ST_WD_ENABLE;
                  end else if (line_has(9, "disable")) begin
                     wd_en = 1'b0; r.cmd_status = scps_pkg::ST_WD_DISABLE;
                  end else r.cmd_status = scps_pkg::ST_BAD_WD_ARG;
               end else if (line_has(0, self_cmd)) r.self_reset_request = 1'b1;
               else r.cmd_status = scps_pkg::ST_UNKNOWN_CMD;
               line_len = 0;
               in_line = 1'b0;
            end else if (line_len < STORE_MAX) begin
               if (line_len < STORE_KEEP) line_buf[line_len] = b;
               line_len++;
            end
         end else begin
            if (b == scps_pkg::MARKER[8*(7-marker_pos) +: 8]) begin
               marker_pos++;
               if (marker_pos >= 8) begin
                  marker_pos = 0; in_line = 1'b1; line_len = 0;
               end
            end else marker_pos = 0;
         end
      end
      r.supply_n = port_bits;
      r.lcd_power = lcd_flag;
      r.watchdog_on = wd_en;
      return r;
   endfunction

   task automatic send_item(logic kind, logic [7:0] b);
      while (!quiet && $urandom_range(99) < 26) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_type <= kind;
      req_rx_byte <= b;
      do @(posedge clock); while (full);
      expected_q.push_back(supervisor_step(kind, b));
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_item(REQ_BYTE, s[i]);
   endtask

   task automatic send_line(string s);
      send_text(marker_txt);
      send_text(s);
      send_item(REQ_BYTE, ($urandom_range(1)) ? scps_pkg::CHAR_LF : scps_pkg::CHAR_CR);
      lines_sent++;
   endtask

   task automatic drain();
      push <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         scps_pkg::CSR_WD_TIMEOUT: cfg_timeout = val;
         scps_pkg::CSR_RESTART_SECONDS: cfg_restart = val[7:0];
         scps_pkg::CSR_DRY_RUN: cfg_dry = val[0];
         default: cfg_mirror = val[0];
      endcase
   endtask

   task automatic configure(logic [15:0] t, logic [7:0] rs, logic d, logic nc);
      drain();
      write_reg(scps_pkg::CSR_WD_TIMEOUT, t);
      write_reg(scps_pkg::CSR_RESTART_SECONDS, {8'h00, rs});
      write_reg(scps_pkg::CSR_DRY_RUN, {15'h0, d});
      write_reg(scps_pkg::CSR_PIN_MIRROR, {15'h0, nc});
      csr_valid <= 1'b0;
   endtask

   // result side
   initial begin
      status_word got, want;
      forever begin
         @(posedge clock);
         if (pop && !empty) begin
            got = {rsp_supply_n, rsp_lcd_power, rsp_watchdog_on, rsp_cmd_status,
                   rsp_report_pin, rsp_report_state, rsp_watchdog_fired,
                   rsp_host_restored, rsp_self_reset_request};
            results_seen++;
            if (expected_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected transaction %h", $realtime, got);
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  errors++;
                  $display("%0t: mismatch expected %h actual %h", $realtime, want, got);
                  $display("   port %h/%h st %0d/%0d pin %0d/%0d", want.supply_n,
                           got.supply_n, want.cmd_status, got.cmd_status,
                           want.report_pin, got.report_pin);
               end
            end
         end
         pop <= (quiet || reset) ? !reset : ($urandom_range(99) >= 26);
      end
   end

   task automatic test_directed();
      send_item(REQ_BYTE, 8'h00);
      send_item(REQ_BYTE, 8'hFF);
      send_text("#=#X");
      send_line("power on 1");
      send_line("power off 8");
      send_line("power on 9");
      send_line("power off usbmic");
      send_line({"power on ", modem_txt});
      send_line("power on wifi");
      send_line("power off usbhub");
      send_line("power on usbhd");
      send_line("power off lcd");
      send_line("power on lcd");
      send_line("power xx 1");
      send_line("powe");
      send_line("lcd hello");
      send_line("watchdog disable");
      send_line("watchdog enable");
      send_line("watchdog maybe");
      send_line(self_cmd);
      send_line(host_cmd);
      send_line("");
      repeat (12) send_item(REQ_TICK, 8'($urandom));
   endtask

   task automatic test_watchdog();
      configure(16'd3, 8'd2, 1'b0, 1'b0);
      repeat (20) send_item(REQ_TICK, 8'($urandom));
      send_line("power on 3");
      send_line(host_cmd);
      repeat (6) send_item(REQ_TICK, 8'($urandom));
      configure(16'd1, 8'd1, 1'b1, 1'b1);
      repeat (6) send_item(REQ_TICK, 8'($urandom));
      configure(16'hFFFF, 8'hFF, 1'b0, 1'b0);
      send_line(host_cmd);
      repeat (5) send_item(REQ_TICK, 8'($urandom));
   endtask

   task automatic test_long_line();
      send_text({marker_txt, "power on "});
      repeat (100) send_item(REQ_BYTE, 8'h41);
      send_item(REQ_BYTE, scps_pkg::CHAR_CR);
   endtask

   task automatic test_random(int count);
      string cmds [14] = '{"power on ", "power off ", "power on", "lcd", "watchdog enable",
         "watchdog disable", "watchdog ", self_cmd,
         host_cmd, "powerXonXusbmic", {"power off ", modem_txt},
         "power on wifi", "power on usbhub", "power off usbhd"};
      string s;
      int n = 0;
      while (n < count) begin
         if ((n / 200) % 3 == 1) quiet = 1'b1;
         else quiet = 1'b0;
         case ($urandom_range(9))
            0, 1: begin
               send_item(REQ_TICK, 8'($urandom));
               n++;
            end
            2: begin
               send_item(REQ_BYTE, 8'($urandom));
               n++;
            end
            default: begin
               s = cmds[$urandom_range(13)];
               if ($urandom_range(1))
                  s = {s, string'(8'(scps_pkg::CHAR_ONE + $urandom_range(8)))};
               if ($urandom_range(7) == 0) s = s.substr(0, $urandom_range(s.len()) - 1);
               send_line(s);
               n += s.len() + 9;
            end
         endcase
         if (n % 500 < 12 && $urandom_range(3) == 0) drain();
      end
      quiet = 1'b0;
   endtask

   initial begin
      host_cmd = $sformatf("REALLY reset the %s", scps_pkg::TAG_HOST);
      self_cmd = $sformatf("REALLY reset the %s", scps_pkg::TAG_MCU);
      marker_txt = $sformatf("#=# %s ", scps_pkg::TAG_MCU);
      modem_txt = $sformatf("%s", scps_pkg::TAG_MODEM);
      for (int i = 0; i < STORE_KEEP; i++) line_buf[i] = 8'h00;
      cfg_timeout = 16'd600; cfg_restart = 8'd10; cfg_dry = 1'b1; cfg_mirror = 1'b1;
      marker_pos = 0; in_line = 1'b0; line_len = 0;
      port_bits = 8'hFA; lcd_flag = 1'b1; wd_en = 1'b1; wd_count = 16'd0;
      restart_count = 8'd0; restart_active = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_watchdog();
      configure(16'd600, 8'd10, 1'b1, 1'b1);
      test_long_line();
      configure(16'd5, 8'd3, 1'b0, 1'b1);
      test_random(580);
      configure(16'd40, 8'd4, 1'b0, 1'b0);
      test_random(580);
      drain();
      $display("covered %0d results, %0d command lines, 4 register settings",
               results_seen, lines_sent);
      if (errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
`default_nettype wire
